>>> rtl/sv39pt_pkg.sv
// ----------------------------------------------------------------------------
// sv39pt_pkg
// Shared widths, microcode word layout and the microcode program of the
// Sv39 page table insert block.
// ----------------------------------------------------------------------------
package sv39pt_pkg;

  localparam int TABLE_PAGES_DEF = 64;

  localparam int VPN_W   = 27;
  localparam int PPN_W   = 44;
  localparam int PERM_W  = 10;
  localparam int PTE_W   = 64;
  localparam int IDX_W   = 9;
  localparam int PPN_LSB = 10;

  // Bit positions of the three 9-bit table indices inside the virtual page.
  localparam int I2_LSB = 18;
  localparam int I1_LSB = 9;
  localparam int I0_LSB = 0;

  // A pointer entry carries only the valid bit in its low ten bits.
  localparam logic [PERM_W-1:0] PTE_PTR_FLAGS = 10'h001;

  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 64;

  // Register index as decoded from paddr bit 3 (8-byte register spacing).
  localparam logic REG_TABLE_BASE = 1'b0;

  typedef enum logic [2:0] {
    ST_CLEAR = 3'd0,
    ST_IDLE  = 3'd1,
    ST_WALK2 = 3'd2,
    ST_WALK1 = 3'd3,
    ST_LEAF  = 3'd4,
    ST_NEW2  = 3'd5,
    ST_NEW1  = 3'd6,
    ST_FAIL  = 3'd7
  } step_t;

  typedef enum logic [2:0] {
    MEM_NONE,
    MEM_RD_ROOT,
    MEM_RD_MID,
    MEM_WR_CLEAR,
    MEM_WR_ROOT,
    MEM_WR_MID,
    MEM_WR_LEAF
  } mem_op_t;

  typedef enum logic [2:0] {
    PG_KEEP,
    PG_P1_PTR,
    PG_P0_PTR,
    PG_P1_NEW,
    PG_P0_NEW
  } page_op_t;

  typedef enum logic [1:0] {
    OUT_NONE,
    OUT_OK,
    OUT_FAIL
  } out_op_t;

  typedef enum logic [2:0] {
    COND_NEXT,
    COND_JUMP,
    COND_ACCEPT,
    COND_CLEAR,
    COND_ROOT,
    COND_MID,
    COND_OUT
  } cond_t;

  typedef struct packed {
    logic     in_ready;
    mem_op_t  mem_op;
    page_op_t page_op;
    out_op_t  out_op;
    cond_t    cond;
    step_t    target;
  } uword_t;

  typedef struct packed {
    logic accept;
    logic clr_last;
    logic ent_inv;
    logic ent_stray;
    logic room1;
    logic room2;
    logic out_full;
  } dp_flags_t;

  // Microcode program: one control word per step.
  function automatic uword_t ucode_rom(step_t step);
    uword_t w;
    w = '{1'b0, MEM_NONE, PG_KEEP, OUT_NONE, COND_JUMP, ST_IDLE};
    case (step)
      ST_CLEAR: w = '{1'b0, MEM_WR_CLEAR, PG_KEEP,   OUT_NONE, COND_CLEAR,  ST_CLEAR};
      ST_IDLE:  w = '{1'b1, MEM_RD_ROOT,  PG_KEEP,   OUT_NONE, COND_ACCEPT, ST_IDLE};
      ST_WALK2: w = '{1'b0, MEM_RD_MID,   PG_P1_PTR, OUT_NONE, COND_ROOT,   ST_NEW2};
      ST_WALK1: w = '{1'b0, MEM_NONE,     PG_P0_PTR, OUT_NONE, COND_MID,    ST_NEW1};
      ST_LEAF:  w = '{1'b0, MEM_WR_LEAF,  PG_KEEP,   OUT_OK,   COND_OUT,    ST_IDLE};
      ST_NEW2:  w = '{1'b0, MEM_WR_ROOT,  PG_P1_NEW, OUT_NONE, COND_NEXT,   ST_NEW1};
      ST_NEW1:  w = '{1'b0, MEM_WR_MID,   PG_P0_NEW, OUT_NONE, COND_JUMP,   ST_LEAF};
      ST_FAIL:  w = '{1'b0, MEM_NONE,     PG_KEEP,   OUT_FAIL, COND_OUT,    ST_IDLE};
      default:  w = '{1'b0, MEM_NONE,     PG_KEEP,   OUT_NONE, COND_JUMP,   ST_IDLE};
    endcase
    return w;
  endfunction

endpackage

>>> rtl/sv39pt_if.sv
// ----------------------------------------------------------------------------
// sv39pt_if
// Valid/ready channels of the page table insert block: mapping requests in,
// results out.
// ----------------------------------------------------------------------------
interface sv39pt_in_if;
  import sv39pt_pkg::*;

  logic              valid;
  logic              ready;
  logic [VPN_W-1:0]  virt_page;
  logic [PPN_W-1:0]  phys_page;
  logic [PERM_W-1:0] perm;
  logic              last_page;

  modport source (output valid, output virt_page, output phys_page, output perm,
                  output last_page, input ready);
  modport sink (input valid, input virt_page, input phys_page, input perm,
                input last_page, output ready);
endinterface

interface sv39pt_out_if;
  import sv39pt_pkg::*;

  logic             valid;
  logic             ready;
  logic             status;
  logic [PTE_W-1:0] leaf_entry;
  logic             region_done;

  modport source (output valid, output status, output leaf_entry, output region_done,
                  input ready);
  modport sink (input valid, input status, input leaf_entry, input region_done,
                output ready);
endinterface

>>> rtl/sv39pt_useq.sv
// ----------------------------------------------------------------------------
// sv39pt_useq
// Microcode sequencer: step counter, program ROM and jump selection.
// ----------------------------------------------------------------------------
module sv39pt_useq (
  input  logic                  clk,
  input  logic                  rst_n,
  input  sv39pt_pkg::dp_flags_t flags,
  output sv39pt_pkg::uword_t    uword
);
  import sv39pt_pkg::*;

  step_t step_r;
  step_t step_nxt;
  step_t step_inc;

  assign uword    = ucode_rom(step_r);
  assign step_inc = step_t'(step_r + 3'd1);

  always_comb begin
    step_nxt = step_r;
    case (uword.cond)
      COND_NEXT:   step_nxt = step_inc;
      COND_JUMP:   step_nxt = uword.target;
      COND_ACCEPT: step_nxt = flags.accept ? step_inc : uword.target;
      COND_CLEAR:  step_nxt = flags.clr_last ? step_inc : uword.target;
      COND_ROOT: begin
        // An invalid root entry needs two fresh pages.
        if (flags.ent_stray || (flags.ent_inv && !flags.room2)) begin
          step_nxt = ST_FAIL;
        end else if (flags.ent_inv) begin
          step_nxt = uword.target;
        end else begin
          step_nxt = step_inc;
        end
      end
      COND_MID: begin
        if (flags.ent_stray || (flags.ent_inv && !flags.room1)) begin
          step_nxt = ST_FAIL;
        end else if (flags.ent_inv) begin
          step_nxt = uword.target;
        end else begin
          step_nxt = step_inc;
        end
      end
      COND_OUT:    step_nxt = flags.out_full ? step_r : uword.target;
      default:     step_nxt = step_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= ST_CLEAR;
    end else begin
      step_r <= step_nxt;
    end
  end

endmodule

>>> rtl/sv39pt_dpath.sv
// ----------------------------------------------------------------------------
// sv39pt_dpath
// Datapath: table page store, walk registers, page allocator and the result
// register, all steered by the microcode word.
// ----------------------------------------------------------------------------
module sv39pt_dpath #(
  parameter int TABLE_PAGES = sv39pt_pkg::TABLE_PAGES_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  sv39pt_pkg::uword_t            uword,
  input  logic                          in_valid,
  input  logic [sv39pt_pkg::VPN_W-1:0]  in_virt_page,
  input  logic [sv39pt_pkg::PPN_W-1:0]  in_phys_page,
  input  logic [sv39pt_pkg::PERM_W-1:0] in_perm,
  input  logic                          in_last_page,
  input  logic [sv39pt_pkg::PPN_W-1:0]  table_base,
  input  logic                          out_ready,
  output sv39pt_pkg::dp_flags_t         flags,
  output logic                          out_valid,
  output logic                          out_status,
  output logic [sv39pt_pkg::PTE_W-1:0]  out_leaf_entry,
  output logic                          out_region_done
);
  import sv39pt_pkg::*;

  localparam int PAGE_W = $clog2(TABLE_PAGES);
  localparam int NF_W   = $clog2(TABLE_PAGES + 1);
  localparam int ADDR_W = PAGE_W + IDX_W;
  localparam int DEPTH  = TABLE_PAGES * (1 << IDX_W);

  logic [PTE_W-1:0]  mem [DEPTH];
  logic [PTE_W-1:0]  rdata_r;

  logic [VPN_W-1:0]  virt_r;
  logic [PPN_W-1:0]  phys_r;
  logic [PERM_W-1:0] perm_r;
  logic              last_r;
  logic [PAGE_W-1:0] page1_r;
  logic [PAGE_W-1:0] page0_r;
  logic [NF_W-1:0]   nf_r;
  logic [ADDR_W-1:0] clr_r;

  logic              out_valid_r;
  logic              out_status_r;
  logic [PTE_W-1:0]  out_leaf_r;
  logic              out_done_r;

  logic              accept;
  logic              out_full;
  logic              out_load;
  logic [PPN_W-1:0]  ptr_idx;
  logic [PPN_W-1:0]  new_ppn;
  logic [PTE_W-1:0]  ptr_pte;
  logic [PTE_W-1:0]  leaf_pte;
  logic [ADDR_W-1:0] raddr;
  logic [ADDR_W-1:0] waddr;
  logic [PTE_W-1:0]  wdata;
  logic              wr_en;
  logic [NF_W:0]     nf_ext;

  assign accept   = in_valid && uword.in_ready;
  assign out_full = out_valid_r && !out_ready;
  assign out_load = (uword.out_op != OUT_NONE) && !out_full;

  // Pool index named by the entry held in the read register, modulo 2^44.
  assign ptr_idx  = rdata_r[PPN_LSB +: PPN_W] - table_base;
  assign new_ppn  = table_base + PPN_W'(nf_r);
  assign ptr_pte  = {(PTE_W - PPN_W - PERM_W)'(0), new_ppn, PTE_PTR_FLAGS};
  assign leaf_pte = {(PTE_W - PPN_W - PERM_W)'(0), phys_r, perm_r};
  assign nf_ext   = {1'b0, nf_r};

  assign flags.accept    = accept;
  assign flags.clr_last  = (clr_r == ADDR_W'(DEPTH - 1));
  assign flags.ent_inv   = !rdata_r[0];
  assign flags.ent_stray = rdata_r[0] && (ptr_idx >= PPN_W'(nf_r));
  assign flags.room1     = (nf_ext + (NF_W + 1)'(1)) <= (NF_W + 1)'(TABLE_PAGES);
  assign flags.room2     = (nf_ext + (NF_W + 1)'(2)) <= (NF_W + 1)'(TABLE_PAGES);
  assign flags.out_full  = out_full;

  always_comb begin
    raddr = {PAGE_W'(0), in_virt_page[I2_LSB +: IDX_W]};
    waddr = clr_r;
    wdata = '0;
    wr_en = 1'b0;
    case (uword.mem_op)
      MEM_NONE:    wr_en = 1'b0;
      MEM_RD_ROOT: raddr = {PAGE_W'(0), in_virt_page[I2_LSB +: IDX_W]};
      MEM_RD_MID:  raddr = {ptr_idx[PAGE_W-1:0], virt_r[I1_LSB +: IDX_W]};
      MEM_WR_CLEAR: begin
        wr_en = 1'b1;
      end
      MEM_WR_ROOT: begin
        wr_en = 1'b1;
        waddr = {PAGE_W'(0), virt_r[I2_LSB +: IDX_W]};
        wdata = ptr_pte;
      end
      MEM_WR_MID: begin
        wr_en = 1'b1;
        waddr = {page1_r, virt_r[I1_LSB +: IDX_W]};
        wdata = ptr_pte;
      end
      MEM_WR_LEAF: begin
        wr_en = 1'b1;
        waddr = {page0_r, virt_r[I0_LSB +: IDX_W]};
        wdata = leaf_pte;
      end
      default:     wr_en = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  // Item, walk and result registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      virt_r <= in_virt_page;
      phys_r <= in_phys_page;
      perm_r <= in_perm;
      last_r <= in_last_page;
    end
    case (uword.page_op)
      PG_P1_PTR: page1_r <= ptr_idx[PAGE_W-1:0];
      PG_P0_PTR: page0_r <= ptr_idx[PAGE_W-1:0];
      PG_P1_NEW: page1_r <= nf_r[PAGE_W-1:0];
      PG_P0_NEW: page0_r <= nf_r[PAGE_W-1:0];
      default:   page1_r <= page1_r;
    endcase
    if (out_load) begin
      out_status_r <= (uword.out_op == OUT_FAIL);
      out_leaf_r   <= (uword.out_op == OUT_FAIL) ? '0 : leaf_pte;
      out_done_r   <= last_r;
    end
  end

  // Control state: allocator, clear sweep, result valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nf_r        <= NF_W'(1);
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (uword.page_op == PG_P1_NEW || uword.page_op == PG_P0_NEW) begin
        nf_r <= nf_r + NF_W'(1);
      end
      if (uword.mem_op == MEM_WR_CLEAR && !flags.clr_last) begin
        clr_r <= clr_r + ADDR_W'(1);
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_leaf_entry  = out_leaf_r;
  assign out_region_done = out_done_r;

endmodule

>>> rtl/sv39_page_table_insert.sv
// After an item is accepted the result register loads once the walk has read both table
// entries and written any fresh pointers and the leaf, or as soon as an error is found.
// The next item is taken in the cycle after that load at the earliest: the walk through
// the store (two reads, up to three writes) handles one item at a time, and a result left
// waiting holds the walker at its last step. Reset (rst_n low, synchronous) starts a sweep
// that clears the whole store; items wait for it, writes don't.
// ----------------------------------------------------------------------------
// sv39_page_table_insert
// Builds a three-level Sv39 page table in an internal pool of table pages, one
// 4 KiB mapping per item, under control of a small microcode program.
// ----------------------------------------------------------------------------
module sv39_page_table_insert #(
  parameter int TABLE_PAGES = sv39pt_pkg::TABLE_PAGES_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  sv39pt_in_if.sink                         in_ch,
  sv39pt_out_if.source                      out_ch,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [sv39pt_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [sv39pt_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [sv39pt_pkg::CFG_DATA_W-1:0] prdata,
  output logic                              pready
);
  import sv39pt_pkg::*;

  // The block is a microcoded walker. The sequencer steps through a short
  // program held in a ROM; each control word tells the datapath which table
  // store access to make, which page register to load and whether to load
  // the result register. Jumps depend on flags the datapath derives from the
  // entry just read: whether it is valid, whether it points outside the pages
  // handed out so far, and whether enough free pages remain.
  //
  // The program has these steps:
  //   clear  - writes zero to one store entry per cycle after reset.
  //   idle   - offers ready and reads the root entry of the incoming item.
  //   walk2  - checks the root entry as the level-1 entry is read; a valid one leads
  //            to walk1, an invalid one to allocation, a stray one or no room to fail.
  //   walk1  - checks the level-1 entry in the same way.
  //   new2   - writes a fresh pointer into the root table.
  //   new1   - writes a fresh pointer into the level-1 table.
  //   leaf   - writes the leaf entry and loads a success result.
  //   fail   - loads an error result; nothing has been written.
  // The capacity check happens before any write, so a failed item leaves the
  // store and the allocator untouched.

  uword_t    uword;
  dp_flags_t flags;

  logic [PPN_W-1:0] table_base_r;
  logic             cfg_wr;
  logic             cfg_hit;

  // Configuration port: one 44-bit register at byte address zero.
  assign pready  = 1'b1;
  assign cfg_hit = (paddr[3] == REG_TABLE_BASE);
  assign cfg_wr  = psel && penable && pwrite && pready && cfg_hit;
  assign prdata  = cfg_hit ? {(CFG_DATA_W - PPN_W)'(0), table_base_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      table_base_r <= '0;
    end else if (cfg_wr) begin
      table_base_r <= pwdata[PPN_W-1:0];
    end
  end

  assign in_ch.ready = uword.in_ready;

  sv39pt_useq u_useq (
    .clk   (clk),
    .rst_n (rst_n),
    .flags (flags),
    .uword (uword)
  );

  sv39pt_dpath #(
    .TABLE_PAGES (TABLE_PAGES)
  ) u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .uword           (uword),
    .in_valid        (in_ch.valid),
    .in_virt_page    (in_ch.virt_page),
    .in_phys_page    (in_ch.phys_page),
    .in_perm         (in_ch.perm),
    .in_last_page    (in_ch.last_page),
    .table_base      (table_base_r),
    .out_ready       (out_ch.ready),
    .flags           (flags),
    .out_valid       (out_ch.valid),
    .out_status      (out_ch.status),
    .out_leaf_entry  (out_ch.leaf_entry),
    .out_region_done (out_ch.region_done)
  );

endmodule

>>> rtl/sv39pt_chk.sv
// ----------------------------------------------------------------------------
// sv39pt_chk
// Port-level checks of the page table insert block, bound to the top level.
// ----------------------------------------------------------------------------
module sv39pt_chk (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic                         out_status,
  input logic [sv39pt_pkg::PTE_W-1:0] out_leaf_entry
);
  import sv39pt_pkg::*;

  // Reset always starts the clearing sweep, so no item can enter right after.
  a_reset_blocks_input: assert property (@(posedge clk)
    !rst_n |=> !in_ready)
    else $error("item offered ready right after reset");

  // One item at a time: the walk starts in the cycle after an accept.
  a_one_item_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second item accepted during a walk");

  // An error result never carries a leaf entry.
  a_fail_leaf_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status) |-> (out_leaf_entry == '0))
    else $error("error result with nonzero leaf entry");

  // A result that is not taken stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_leaf_entry)))
    else $error("stalled result changed");

endmodule

bind sv39_page_table_insert sv39pt_chk u_chk (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_ch.valid),
  .in_ready       (in_ch.ready),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_status     (out_ch.status),
  .out_leaf_entry (out_ch.leaf_entry)
);
